@@ rtl/spvg_pkg.sv @@
// Shared constants and the arctangent table for the star polygon vertex generator.
// No dependencies.
`default_nettype none

package spvg_pkg;

   // default build values
   localparam int MAX_POINTS_DEF   = 32;
   localparam int FRAC_BITS_DEF    = 4;
   localparam int CORDIC_STEPS_DEF = 16;

   // fixed field widths
   localparam int COORD_W   = 16;
   localparam int OUT_W     = 22;
   localparam int COUNT_W   = 6;
   localparam int PCT_W     = 7;
   localparam int ANGLE_W   = 32;
   localparam int GUARD_BITS = 8;
   localparam int ATAN_LEN  = 24;

   // 1/K in Q24
   localparam int INV_GAIN_Q24 = 10188014;
   localparam int PCT_DIV      = 100;
   localparam int PCT_MAX      = 100;

   // ceil(2^34 / 100), exact floor divide by 100 for values below 2^27
   localparam int RECIP_100   = 171798692;
   localparam int RECIP_SHIFT = 34;
   localparam int RECIP_W     = 28;

   // csr register indexes
   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_INNER_RATIO  = 1'b1;

   // arctangent of 2^-s in 2^-32 turn units
   function automatic logic [ANGLE_W-1:0] atan_turn(input int s);
      logic [ANGLE_W-1:0] r;
      r = '0;
      case (s)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/spvg_cordic_cell.sv @@
// One rotation-mode CORDIC iteration with registered outputs.
// Depends on spvg_pkg for the arctangent table.
`default_nettype none

module spvg_cordic_cell import spvg_pkg::*; #(
   parameter int W     = 32,
   parameter int STAGE = 0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic signed [W-1:0]       in_x,
   input  wire logic signed [W-1:0]       in_y,
   input  wire logic signed [ANGLE_W-1:0] in_z,
   output logic                           out_valid_ff,
   output logic signed [W-1:0]            out_x_ff,
   output logic signed [W-1:0]            out_y_ff,
   output logic signed [ANGLE_W-1:0]      out_z_ff
);

   localparam logic [ANGLE_W-1:0] ATAN = atan_turn(STAGE);

   logic signed [W-1:0]       sx, sy;
   logic signed [W-1:0]       out_x_in, out_y_in;
   logic signed [ANGLE_W-1:0] out_z_in;

   // one micro-rotation, direction from sign of residual angle
   always_comb begin
      sx = in_y >>> STAGE;
      sy = in_x >>> STAGE;
      if (!in_z[ANGLE_W-1]) begin
         out_x_in = in_x - sx;
         out_y_in = in_y + sy;
         out_z_in = in_z - $signed(ATAN);
      end else begin
         out_x_in = in_x + sx;
         out_y_in = in_y - sy;
         out_z_in = in_z + $signed(ATAN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
   end

endmodule

`default_nettype wire

@@ rtl/star_polygon_vertex_generator_unit.sv @@
// Top level: star vertex sequencer around a chain of CORDIC cells.
// Depends on spvg_pkg and spvg_cordic_cell.
//
//   channel | ports                                   | direction
//   req     | req_valid/req_stall, center_*, edge_*   | in
//   rsp     | rsp_valid/rsp_stall, vertex_*, flags    | out
//   csr     | csr_write, csr_index, csr_data          | in
//
// Once a star is accepted, the divide state derives the angle step (divide of
// 2^31 by N). Each vertex then passes the CORDIC chain, gain removal and
// rounding; an inner one also takes the reciprocal divide by 100 before its word
// is offered. STEPS is min(CORDIC_STEPS, 24). A stalled word holds back the next.
// A star is taken only when the previous star's last word has left.
// Synchronous reset clears control state; a stalled output word holds.
`default_nettype none

module star_polygon_vertex_generator_unit import spvg_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic                      csr_index,
   input  wire logic [PCT_W-1:0]          csr_data,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [COORD_W-1:0] req_center_x,
   input  wire logic signed [COORD_W-1:0] req_center_y,
   input  wire logic signed [COORD_W-1:0] req_edge_x,
   input  wire logic signed [COORD_W-1:0] req_edge_y,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [OUT_W-1:0]        rsp_vertex_x,
   output logic signed [OUT_W-1:0]        rsp_vertex_y,
   output logic                           rsp_is_outer,
   output logic                           rsp_last_vertex
);

   localparam int WORK_SHIFT = FRAC_BITS + GUARD_BITS;
   localparam int W     = COORD_W + 1 + WORK_SHIFT + 3;
   localparam int STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int PW    = W + 25;
   localparam int DW    = W + PCT_W;
   localparam int CW    = $clog2(DW + 1);
   localparam int IW    = $clog2(2 * MAX_POINTS);
   localparam int SW    = OUT_W > (W + 1) ? OUT_W : (W + 1);
   localparam int SPLIT = 20;
   localparam int QH_W  = DW - SPLIT;
   localparam int LW    = SPLIT + PCT_W;
   localparam int MW    = RECIP_SHIFT + LW;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_ISSUE = 4'd2;
   localparam logic [3:0] S_WAIT  = 4'd3;
   localparam logic [3:0] S_ROUND = 4'd4;
   localparam logic [3:0] S_D100  = 4'd5;
   localparam logic [3:0] S_FIN   = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   // configuration registers
   logic [COUNT_W-1:0] vcount_ff;
   logic [PCT_W-1:0]   ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= COUNT_W'(5);
         ratio_ff  <= PCT_W'(40);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vcount_ff <= csr_data[COUNT_W-1:0];
            CSR_INNER_RATIO:  ratio_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer registers
   logic [3:0] state_ff, state_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [PCT_W-1:0]   pct_ff, pct_in;
   logic [ANGLE_W-1:0] qstep_ff, qstep_in;
   logic [COUNT_W-1:0] rstep_ff, rstep_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [ANGLE_W-1:0] ang_ff, ang_in;
   logic [COUNT_W-1:0] arem_ff, arem_in;
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [W-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [DW-1:0]      dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [QH_W-1:0]    qhx_ff, qhx_in, qhy_ff, qhy_in;
   logic [LW-1:0]      rlx_ff, rlx_in, rly_ff, rly_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic               outer_ff, outer_in, last_ff, last_in;

   // chain wiring
   logic                      cv  [STEPS+1];
   logic signed [W-1:0]       cxw [STEPS+1];
   logic signed [W-1:0]       cyw [STEPS+1];
   logic signed [ANGLE_W-1:0] czw [STEPS+1];

   genvar g;
   generate
      for (g = 0; g < STEPS; g++) begin : g_cell
         spvg_cordic_cell #(.W(W), .STAGE(g)) u_cell (
            .clock        (clock),
            .reset        (reset),
            .in_valid     (cv[g]),
            .in_x         (cxw[g]),
            .in_y         (cyw[g]),
            .in_z         (czw[g]),
            .out_valid_ff (cv[g+1]),
            .out_x_ff     (cxw[g+1]),
            .out_y_ff     (cyw[g+1]),
            .out_z_ff     (czw[g+1])
         );
      end
   endgenerate

   // quadrant pre-rotation feeding the chain
   logic [1:0]          quad;
   logic [ANGLE_W-1:0]  resid;
   logic signed [W-1:0] start_x, start_y;

   always_comb begin
      quad  = 2'((ang_ff + ANGLE_W'(32'h2000_0000)) >> 30);
      resid = ang_ff - {quad, 30'd0};
      case (quad)
         2'd1:    begin start_x = -by_ff; start_y = bx_ff;  end
         2'd2:    begin start_x = -bx_ff; start_y = -by_ff; end
         2'd3:    begin start_x = by_ff;  start_y = -bx_ff; end
         default: begin start_x = bx_ff;  start_y = by_ff;  end
      endcase
   end

   assign cv[0]  = (state_ff == S_ISSUE);
   assign cxw[0] = start_x;
   assign cyw[0] = start_y;
   assign czw[0] = $signed(resid);

   // datapath helpers
   logic signed [COORD_W:0] dx, dy;
   logic [COUNT_W:0]        dtrial;
   logic [COUNT_W-1:0]      vc_clamp;
   logic [PCT_W-1:0]        pct_clamp;
   logic [COUNT_W-1:0]      asum;
   logic [W-1:0]            magx, magy;
   logic [MW-1:0]           mhx, mhy, mlx, mly;
   logic [QH_W-1:0]         remx, remy;
   logic [DW-1:0]           qx, qy;
   logic signed [W-1:0]     rx, ry, offx, offy;
   logic signed [SW-1:0]    sumx, sumy;
   logic [IW-1:0]           last_idx;
   logic                    is_last;

   function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi, lo;
      hi = SW'((1 << (OUT_W - 1)) - 1);
      lo = -SW'(1 << (OUT_W - 1));
      if (v > hi) return OUT_W'(hi);
      if (v < lo) return OUT_W'(lo);
      return OUT_W'(v);
   endfunction

   always_comb begin
      dx = $signed({req_edge_x[COORD_W-1], req_edge_x})
         - $signed({req_center_x[COORD_W-1], req_center_x});
      dy = $signed({req_edge_y[COORD_W-1], req_edge_y})
         - $signed({req_center_y[COORD_W-1], req_center_y});
      if (vcount_ff < COUNT_W'(2))               vc_clamp = COUNT_W'(2);
      else if (vcount_ff > COUNT_W'(MAX_POINTS)) vc_clamp = COUNT_W'(MAX_POINTS);
      else                                       vc_clamp = vcount_ff;
      pct_clamp = (ratio_ff > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : ratio_ff;
      dtrial = {rstep_ff, (cnt_ff == '0)};
      asum   = arem_ff + rstep_ff;
      magx   = vx_ff[W-1] ? W'(-vx_ff) : W'(vx_ff);
      magy   = vy_ff[W-1] ? W'(-vy_ff) : W'(vy_ff);
      // divide by 100 in two reciprocal steps: upper part, then remainder and lower part
      mhx    = MW'(dvx_ff[DW-1:SPLIT]) * MW'(RECIP_100);
      mhy    = MW'(dvy_ff[DW-1:SPLIT]) * MW'(RECIP_100);
      remx   = dvx_ff[DW-1:SPLIT] - QH_W'(qhx_ff * PCT_DIV);
      remy   = dvy_ff[DW-1:SPLIT] - QH_W'(qhy_ff * PCT_DIV);
      mlx    = MW'(rlx_ff) * MW'(RECIP_100);
      mly    = MW'(rly_ff) * MW'(RECIP_100);
      qx     = {qhx_ff, mlx[RECIP_SHIFT +: SPLIT]};
      qy     = {qhy_ff, mly[RECIP_SHIFT +: SPLIT]};
      rx     = vx_ff[W-1] ? -$signed(qx[W-1:0]) : $signed(qx[W-1:0]);
      ry     = vy_ff[W-1] ? -$signed(qy[W-1:0]) : $signed(qy[W-1:0]);
      offx   = (vx_ff + W'(128)) >>> GUARD_BITS;
      offy   = (vy_ff + W'(128)) >>> GUARD_BITS;
      sumx   = SW'(offx) + (SW'(cx_ff) <<< FRAC_BITS);
      sumy   = SW'(offy) + (SW'(cy_ff) <<< FRAC_BITS);
      last_idx = IW'({n_ff, 1'b0} - (COUNT_W + 1)'(1));
      is_last  = (idx_ff == last_idx);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; bx_in = bx_ff; by_in = by_ff;
      n_in = n_ff; pct_in = pct_ff;
      qstep_in = qstep_ff; rstep_in = rstep_ff; cnt_in = cnt_ff;
      idx_in = idx_ff; ang_in = ang_ff; arem_in = arem_ff;
      px_in = px_ff; py_in = py_ff; vx_in = vx_ff; vy_in = vy_ff;
      dvx_in = dvx_ff; dvy_in = dvy_ff; qhx_in = qhx_ff; qhy_in = qhy_ff;
      rlx_in = rlx_ff; rly_in = rly_ff;
      rsp_valid_in = rsp_valid_ff;
      ox_in = ox_ff; oy_in = oy_ff; outer_in = outer_ff; last_in = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cx_in    = req_center_x;
               cy_in    = req_center_y;
               bx_in    = W'(dy) <<< WORK_SHIFT;
               by_in    = (-W'(dx)) <<< WORK_SHIFT;
               n_in     = vc_clamp;
               pct_in   = pct_clamp;
               qstep_in = '0;
               rstep_in = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         // restoring divide of 2^31 by n, one bit a cycle
         S_DIV: begin
            if (dtrial >= {1'b0, n_ff}) begin
               rstep_in = COUNT_W'(dtrial - {1'b0, n_ff});
               qstep_in = {qstep_ff[ANGLE_W-2:0], 1'b1};
            end else begin
               rstep_in = COUNT_W'(dtrial);
               qstep_in = {qstep_ff[ANGLE_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ANGLE_W - 1)) begin
               idx_in   = '0;
               ang_in   = '0;
               arem_in  = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: state_in = S_WAIT;
         // gain removal product
         S_WAIT: begin
            if (cv[STEPS]) begin
               px_in = PW'(cxw[STEPS]) * PW'(INV_GAIN_Q24);
               py_in = PW'(cyw[STEPS]) * PW'(INV_GAIN_Q24);
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            vx_in = W'((px_ff + (PW'(1) <<< 23)) >>> 24);
            vy_in = W'((py_ff + (PW'(1) <<< 23)) >>> 24);
            state_in = idx_ff[0] ? S_D100 : S_FIN;
            cnt_in = '0;
         end
         // inner radius: (mag * pct + 50) / 100, sign restored afterwards
         S_D100: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(0)) begin
               dvx_in = DW'(magx) * DW'(pct_ff) + DW'(PCT_DIV / 2);
               dvy_in = DW'(magy) * DW'(pct_ff) + DW'(PCT_DIV / 2);
            end else if (cnt_ff == CW'(1)) begin
               qhx_in = mhx[RECIP_SHIFT +: QH_W];
               qhy_in = mhy[RECIP_SHIFT +: QH_W];
            end else if (cnt_ff == CW'(2)) begin
               rlx_in = {remx[PCT_W-1:0], dvx_ff[SPLIT-1:0]};
               rly_in = {remy[PCT_W-1:0], dvy_ff[SPLIT-1:0]};
            end else begin
               vx_in    = rx;
               vy_in    = ry;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            ox_in        = sat(sumx);
            oy_in        = sat(sumy);
            outer_in     = !idx_ff[0];
            last_in      = is_last;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               idx_in = idx_ff + IW'(1);
               if (asum >= n_ff) begin
                  arem_in = asum - n_ff;
                  ang_in  = ang_ff + qstep_ff + ANGLE_W'(1);
               end else begin
                  arem_in = asum;
                  ang_in  = ang_ff + qstep_ff;
               end
               state_in = is_last ? S_IDLE : S_ISSUE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; bx_ff <= bx_in; by_ff <= by_in;
      n_ff <= n_in; pct_ff <= pct_in;
      qstep_ff <= qstep_in; rstep_ff <= rstep_in; cnt_ff <= cnt_in;
      idx_ff <= idx_in; ang_ff <= ang_in; arem_ff <= arem_in;
      px_ff <= px_in; py_ff <= py_in; vx_ff <= vx_in; vy_ff <= vy_in;
      dvx_ff <= dvx_in; dvy_ff <= dvy_in; qhx_ff <= qhx_in; qhy_ff <= qhy_in;
      rlx_ff <= rlx_in; rly_ff <= rly_in;
      ox_ff <= ox_in; oy_ff <= oy_in; outer_ff <= outer_in; last_ff <= last_in;
   end

   // ports
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_x    = ox_ff;
   assign rsp_vertex_y    = oy_ff;
   assign rsp_is_outer    = outer_ff;
   assign rsp_last_vertex = last_ff;

endmodule

`default_nettype wire
